// ----- design/wlh_pkg.sv -----
// Shared types, constants and helper functions for the four-lane word hash.
package wlh_pkg;

    localparam int LEN_BITS   = 32;
    localparam int CNT_W      = LEN_BITS - 2;
    localparam int WORD_W     = 64;
    localparam int LEN_IN_W   = 32;
    localparam int TDATA_W    = 2 * WORD_W + LEN_IN_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MULA = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MULB = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MULC = 64'h94D049BB133111EB;

    localparam logic [5:0] ROT_ONE   = 6'd11;
    localparam logic [5:0] ROT_TWO   = 6'd17;
    localparam logic [5:0] ROT_THREE = 6'd23;
    localparam logic [5:0] ROT_FOUR  = 6'd57;
    localparam logic [5:0] SHR_FOLD  = 6'd29;
    localparam logic [5:0] SHR_MIXA  = 6'd31;
    localparam logic [5:0] SHR_MIXB  = 6'd37;
    localparam logic [5:0] SHR_LAST  = 6'd41;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        LANE_ONE   = 2'd0,
        LANE_TWO   = 2'd1,
        LANE_THREE = 2'd2,
        LANE_FOUR  = 2'd3
    } lane_sel_t;

    typedef struct packed
    {
        cmd_t                 kind;
        lane_sel_t            lane;
        logic                 upd;
        logic                 fin;
        logic                 tail;
        logic [WORD_W-1:0]    data;
        logic [LEN_BITS-1:0]  len;
    } q_entry_t;

    typedef struct packed
    {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed
    {
        logic              done;
        logic [WORD_W-1:0] p;
    } mul_rsp_t;

    typedef enum logic [1:0]
    {
        MS_IDLE,
        MS_LO,
        MS_MID_A,
        MS_MID_B
    } mul_step_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_BASE,
        B_LANES,
        B_MIX,
        B_FOLD,
        B_FMUL,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0]
    {
        FM_A,
        FM_B,
        FM_G
    } fmul_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] k);
        if (k == 6'd0)
        begin
            return x;
        end
        return (x << k) | (x >> (7'd64 - {1'b0, k}));
    endfunction

    function automatic logic [63:0] xorshr(input logic [63:0] x, input logic [5:0] k);
        return x ^ (x >> k);
    endfunction

    function automatic logic [63:0] absorb(input logic [63:0] lane, input logic [63:0] word,
                                           input logic [63:0] nbr, input logic [5:0] k);
        return rotl64((lane ^ word) + nbr, k);
    endfunction

    function automatic logic [63:0] lane_mult(input lane_sel_t sel);
        logic [63:0] m;
        unique case (sel)
            LANE_ONE:   m = GOLD;
            LANE_TWO:   m = MULA;
            LANE_THREE: m = MULB;
            LANE_FOUR:  m = MULC;
        endcase
        return m;
    endfunction

endpackage

// ----- design/wlh_fifo.sv -----
// Small queue of classified items between the front and back ends.
module wlh_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wlh_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output wlh_pkg::q_entry_t pop_entry,
    output logic              empty
);
    import wlh_pkg::*;

    q_entry_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_next;
    logic [FIFO_AW:0]    count_reg;
    logic [FIFO_AW:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/wlh_front.sv -----
// Front end: accepts items, tracks the open message and classifies each word.
module wlh_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [wlh_pkg::TDATA_W-1:0]   s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          q_push,
    output wlh_pkg::q_entry_t             q_entry,
    input  logic                          q_full
);
    import wlh_pkg::*;

    logic                 open_reg;
    logic                 open_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [LEN_BITS-1:0]  len_reg;
    logic [LEN_BITS-1:0]  len_next;

    logic                 accept;
    cmd_t                 cmd;
    logic [WORD_W-1:0]    word_in;
    logic [WORD_W-1:0]    seed_in;
    logic [LEN_BITS-1:0]  len_in;
    logic [LEN_BITS-4:0]  whole;
    logic [LEN_BITS-4:0]  group_words;
    logic [CNT_W-1:0]     needed;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 in_group;
    logic                 in_whole;
    logic                 last;
    logic [WORD_W-1:0]    tail_mask;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);
    assign word_in       = s_axis_tdata[WORD_W-1:0];
    assign seed_in       = s_axis_tdata[WORD_W +: WORD_W];
    assign len_in        = s_axis_tdata[2*WORD_W +: LEN_BITS];

    assign whole       = len_reg[LEN_BITS-1:3];
    assign group_words = {len_reg[LEN_BITS-1:5], 2'b00};
    assign needed      = {1'b0, whole} + CNT_W'(|len_reg[2:0]);
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign in_group    = (cnt_reg < {1'b0, group_words});
    assign in_whole    = (cnt_reg < {1'b0, whole});
    assign last        = (cnt_inc == needed);
    assign tail_mask   = (64'd1 << {len_reg[2:0], 3'b000}) - 64'd1;

    always_comb
    begin
        q_push    = 1'b0;
        q_entry   = '0;
        open_next = open_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        if (accept)
        begin
            priority if (cmd == CMD_START)
            begin
                q_push        = 1'b1;
                q_entry.kind  = CMD_START;
                q_entry.data  = seed_in;
                q_entry.len   = len_in;
                q_entry.fin   = (len_in == '0);
                open_next     = (len_in != '0);
                cnt_next      = '0;
                len_next      = len_in;
            end
            else if (open_reg)
            begin
                q_push        = 1'b1;
                q_entry.kind  = CMD_DATA;
                q_entry.lane  = in_group ? lane_sel_t'(cnt_reg[1:0]) : LANE_ONE;
                q_entry.upd   = in_whole;
                q_entry.tail  = !in_whole;
                q_entry.data  = in_whole ? word_in : (word_in & tail_mask);
                q_entry.len   = len_reg;
                q_entry.fin   = last;
                cnt_next      = cnt_inc;
                if (last)
                begin
                    open_next = 1'b0;
                end
            end
            else
            begin
                q_push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            cnt_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
        end
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Item pushed into a full queue.");

    a_count_below_needed: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (cnt_reg < needed))
        else $error("Open message has already taken all its words.");
`endif

endmodule

// ----- design/wlh_mul.sv -----
// Iterative 64x64 modulo 2^64 multiplier built on one shared 32x32 multiplier.
module wlh_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  wlh_pkg::mul_req_t req,
    output wlh_pkg::mul_rsp_t rsp
);
    import wlh_pkg::*;

    mul_step_t    step_reg;
    mul_step_t    step_next;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  acc_reg;
    logic [63:0]  acc_next;
    logic         done_reg;
    logic         done_next;
    logic [31:0]  op_x;
    logic [31:0]  op_y;
    logic [63:0]  prod;
    logic         load;

    assign prod     = 64'(op_x) * 64'(op_y);
    assign load     = (step_reg == MS_IDLE) && req.start;
    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    always_comb
    begin
        step_next = step_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        op_x      = a_reg[31:0];
        op_y      = b_reg[31:0];
        unique case (step_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    step_next = MS_LO;
                end
            end
            MS_LO:
            begin
                acc_next  = prod;
                step_next = MS_MID_A;
            end
            MS_MID_A:
            begin
                op_y      = b_reg[63:32];
                acc_next  = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                step_next = MS_MID_B;
            end
            MS_MID_B:
            begin
                op_x      = a_reg[63:32];
                acc_next  = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                step_next = MS_IDLE;
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- design/wlh_back.sv -----
// Back end: lane state, seeding, word absorption and the finalizer sequence.
module wlh_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  wlh_pkg::q_entry_t           q_entry,
    output logic                        q_pop,
    input  logic [5:0]                  cross_rot,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [wlh_pkg::WORD_W-1:0]  m_axis_tdata
);
    import wlh_pkg::*;

    back_state_t  state_reg;
    back_state_t  state_next;
    logic [63:0]  l1_reg;
    logic [63:0]  l1_next;
    logic [63:0]  l2_reg;
    logic [63:0]  l2_next;
    logic [63:0]  l3_reg;
    logic [63:0]  l3_next;
    logic [63:0]  l4_reg;
    logic [63:0]  l4_next;
    logic [63:0]  base_reg;
    logic [63:0]  base_next;
    logic [63:0]  tword_reg;
    logic [63:0]  tword_next;
    logic         tail_reg;
    logic         tail_next;
    logic         fin_reg;
    logic         fin_next;
    lane_sel_t    idx_reg;
    lane_sel_t    idx_next;
    fmul_t        fm_reg;
    fmul_t        fm_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [63:0]  out_data_reg;
    logic [63:0]  out_data_next;

    mul_req_t     mreq;
    mul_rsp_t     mrsp;
    logic [63:0]  base_new;
    logic [63:0]  mix_t;
    logic [63:0]  h1;
    logic [63:0]  fold;

    wlh_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign base_new = base_reg ^ mrsp.p;
    assign mix_t    = rotl64(l2_reg ^ l1_reg, cross_rot);
    assign h1       = tail_reg ? absorb(l1_reg, tword_reg, l2_reg, ROT_ONE) : l1_reg;
    assign fold     = xorshr(h1 ^ l2_reg ^ l3_reg ^ l4_reg, SHR_FOLD);

    always_comb
    begin
        state_next     = state_reg;
        l1_next        = l1_reg;
        l2_next        = l2_reg;
        l3_next        = l3_reg;
        l4_next        = l4_reg;
        base_next      = base_reg;
        tword_next     = tword_reg;
        tail_next      = tail_reg;
        fin_next       = fin_reg;
        idx_next       = idx_reg;
        fm_next        = fm_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mreq.start     = 1'b0;
        mreq.a         = base_reg;
        mreq.b         = GOLD;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.kind)
                        CMD_START:
                        begin
                            mreq.start = 1'b1;
                            mreq.a     = {{(WORD_W - LEN_BITS){1'b0}}, q_entry.len};
                            mreq.b     = GOLD;
                            base_next  = q_entry.data;
                            fin_next   = q_entry.fin;
                            tail_next  = 1'b0;
                            state_next = B_BASE;
                        end
                        CMD_DATA:
                        begin
                            if (q_entry.upd)
                            begin
                                unique case (q_entry.lane)
                                    LANE_ONE:
                                        l1_next = absorb(l1_reg, q_entry.data, l2_reg, ROT_ONE);
                                    LANE_TWO:
                                        l2_next = absorb(l2_reg, q_entry.data, l3_reg, ROT_TWO);
                                    LANE_THREE:
                                        l3_next = absorb(l3_reg, q_entry.data, l4_reg, ROT_THREE);
                                    LANE_FOUR:
                                        l4_next = absorb(l4_reg, q_entry.data, l1_reg, ROT_FOUR);
                                endcase
                            end
                            if (q_entry.fin)
                            begin
                                tail_next  = q_entry.tail;
                                tword_next = q_entry.data;
                                state_next = B_MIX;
                            end
                        end
                    endcase
                end
            end
            B_BASE:
            begin
                if (mrsp.done)
                begin
                    base_next  = base_new;
                    mreq.start = 1'b1;
                    mreq.a     = base_new;
                    mreq.b     = lane_mult(LANE_ONE);
                    idx_next   = LANE_ONE;
                    state_next = B_LANES;
                end
            end
            B_LANES:
            begin
                if (mrsp.done)
                begin
                    unique case (idx_reg)
                        LANE_ONE:   l1_next = mrsp.p;
                        LANE_TWO:   l2_next = mrsp.p;
                        LANE_THREE: l3_next = mrsp.p;
                        LANE_FOUR:  l4_next = mrsp.p;
                    endcase
                    if (idx_reg != LANE_FOUR)
                    begin
                        idx_next   = lane_sel_t'(idx_reg + 2'd1);
                        mreq.start = 1'b1;
                        mreq.a     = base_reg;
                        mreq.b     = lane_mult(lane_sel_t'(idx_reg + 2'd1));
                    end
                    else
                    begin
                        state_next = fin_reg ? B_MIX : B_IDLE;
                    end
                end
            end
            B_MIX:
            begin
                if (cross_rot != 6'd0)
                begin
                    l2_next = mix_t;
                    l1_next = l1_reg ^ mix_t;
                end
                state_next = B_FOLD;
            end
            B_FOLD:
            begin
                mreq.start = 1'b1;
                mreq.a     = fold;
                mreq.b     = MULA;
                fm_next    = FM_A;
                state_next = B_FMUL;
            end
            B_FMUL:
            begin
                if (mrsp.done)
                begin
                    unique case (fm_reg)
                        FM_A:
                        begin
                            mreq.start = 1'b1;
                            mreq.a     = xorshr(mrsp.p, SHR_MIXA);
                            mreq.b     = MULB;
                            fm_next    = FM_B;
                        end
                        FM_B:
                        begin
                            mreq.start = 1'b1;
                            mreq.a     = xorshr(mrsp.p, SHR_MIXB);
                            mreq.b     = GOLD;
                            fm_next    = FM_G;
                        end
                        FM_G:
                        begin
                            base_next  = xorshr(mrsp.p, SHR_LAST);
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = base_reg;
                    state_next     = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        tword_reg    <= tword_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            l1_reg        <= '0;
            l2_reg        <= '0;
            l3_reg        <= '0;
            l4_reg        <= '0;
            tail_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            idx_reg       <= LANE_ONE;
            fm_reg        <= FM_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            l1_reg        <= l1_next;
            l2_reg        <= l2_next;
            l3_reg        <= l3_next;
            l4_reg        <= l4_next;
            tail_reg      <= tail_next;
            fin_reg       <= fin_next;
            idx_reg       <= idx_next;
            fm_reg        <= fm_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_stray_product: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !mrsp.done)
        else $error("Multiplier result arrived with no request outstanding.");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE && !q_empty))
        else $error("Queue popped outside the idle state.");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_OUT))
        else $error("Result appeared without a finished hash.");
`endif

endmodule

// ----- design/four_lane_word_hash_64_core.sv -----
// Top level of the four-lane 64-bit word hash: configuration register and block wiring.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: data_word, seed, msg_len; tuser: cmd
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: hash_value
// cfg       in         cfg_we                       cfg_wdata: cross_rotation
//
// A data word is absorbed by the back end in its idle state; a start item is followed by
// the seeding products and the closing word of a message by the finalizer products, all made
// on the shared 32x32 multiplier, which builds each 64-bit product from its partial products.
// A four-entry queue lets the front end keep taking items while the back end works.
// Reset clears all control state and the lanes; no clearing pass is needed.
// A finished hash waits in the output register while new items are still taken.
module four_lane_word_hash_64_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [5:0]                    cfg_wdata,      // cross_rotation
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [wlh_pkg::TDATA_W-1:0]   s_axis_tdata,   // data_word, seed, msg_len
    input  logic                          s_axis_tuser,   // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wlh_pkg::WORD_W-1:0]    m_axis_tdata    // hash_value
);
    import wlh_pkg::*;

    logic [5:0]  cross_rot_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    q_entry_t    push_entry;
    q_entry_t    pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_rot_reg <= '0;
        end
        else if (cfg_we)
        begin
            cross_rot_reg <= cfg_wdata;
        end
    end

    wlh_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_push        (q_push),
        .q_entry       (push_entry),
        .q_full        (q_full)
    );

    wlh_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    wlh_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_entry       (pop_entry),
        .q_pop         (q_pop),
        .cross_rot     (cross_rot_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking stream testbench for the four-lane word hash core with its own hash predictor.
module tb;
    import wlh_pkg::*;

    localparam int LIMIT = 400000;
    localparam int SETTLE = 200;

    typedef struct
    {
        cmd_t        kind;
        logic [63:0] word;
        logic [63:0] seed;
        logic [31:0] len_b;
    } msg_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;

    msg_item_t send_queue[$];
    msg_item_t offered;
    logic [63:0] hashes_due[$];

    logic [63:0] acc1, acc2, acc3, acc4;
    logic [31:0] byte_total;
    logic [31:0] words_seen;
    bit in_message;
    logic [5:0] cross_rot;

    int idle_pct = 32;
    int errors = 0;
    int cycles = 0;
    int items_accepted = 0;
    int hashes_checked = 0;
    int messages_planned = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    four_lane_word_hash_64_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned k);
        return (x << k) | (x >> (64 - k));
    endfunction

    function automatic logic [63:0] close_hash(input bit at_tail, input logic [63:0] word);
        logic [63:0] h1, h2, h3, h4, keep;
        h1 = acc1;
        h2 = acc2;
        h3 = acc3;
        h4 = acc4;
        if (cross_rot != 6'd0)
        begin
            h2 ^= h1;
            h2 = rol64(h2, cross_rot);
            h1 ^= h2;
        end
        if (at_tail)
        begin
            keep = (64'd1 << (8 * byte_total[2:0])) - 64'd1;
            h1 ^= word & keep;
            h1 = rol64(h1 + h2, ROT_ONE);
        end
        h1 ^= h2;
        h3 ^= h4;
        h1 ^= h3;
        h1 ^= h1 >> SHR_FOLD;
        h1 = h1 * MULA;
        h1 ^= h1 >> SHR_MIXA;
        h1 = h1 * MULB;
        h1 ^= h1 >> SHR_MIXB;
        h1 = h1 * GOLD;
        h1 ^= h1 >> SHR_LAST;
        return h1;
    endfunction

    // Advances the predicted hash state by one accepted item; returns 1 when a hash is due.
    function automatic bit hash_absorb(input msg_item_t it, output logic [63:0] digest);
        logic [63:0] base;
        logic [31:0] whole, grp, needed;
        bit at_tail;
        digest = '0;
        if (it.kind == CMD_START)
        begin
            base = it.seed ^ ({32'd0, it.len_b} * GOLD);
            acc1 = base * GOLD;
            acc2 = base * MULA;
            acc3 = base * MULB;
            acc4 = base * MULC;
            byte_total = it.len_b;
            words_seen = '0;
            if (it.len_b == 32'd0)
            begin
                in_message = 1'b0;
                digest = close_hash(1'b0, 64'd0);
                return 1'b1;
            end
            in_message = 1'b1;
            return 1'b0;
        end
        if (!in_message)
        begin
            return 1'b0;
        end
        whole = byte_total >> 3;
        grp = (byte_total >> 5) << 2;
        needed = whole + ((byte_total[2:0] != 3'd0) ? 32'd1 : 32'd0);
        at_tail = words_seen >= whole;
        if (words_seen < grp)
        begin
            case (words_seen[1:0])
                2'd0: acc1 = rol64((acc1 ^ it.word) + acc2, ROT_ONE);
                2'd1: acc2 = rol64((acc2 ^ it.word) + acc3, ROT_TWO);
                2'd2: acc3 = rol64((acc3 ^ it.word) + acc4, ROT_THREE);
                default: acc4 = rol64((acc4 ^ it.word) + acc1, ROT_FOUR);
            endcase
        end
        else if (words_seen < whole)
        begin
            acc1 = rol64((acc1 ^ it.word) + acc2, ROT_ONE);
        end
        words_seen = words_seen + 32'd1;
        if (words_seen >= needed)
        begin
            in_message = 1'b0;
            digest = close_hash(at_tail, it.word);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    task automatic add_item(input cmd_t kind, input logic [63:0] word, input logic [63:0] seed,
                            input logic [31:0] len_b);
        msg_item_t it;
        it.kind = kind;
        it.word = word;
        it.seed = seed;
        it.len_b = len_b;
        send_queue.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_data(input logic [63:0] word);
        add_item(CMD_DATA, word, rand64(), $urandom);
    endtask

    task automatic add_start(input logic [63:0] seed, input logic [31:0] len_b);
        add_item(CMD_START, rand64(), seed, len_b);
        messages_planned++;
    endtask

    // Queues a start and every word that the message needs; returns the number of items.
    task automatic add_message(input logic [63:0] seed, input logic [31:0] len_b, output int n);
        int words;
        words = (len_b + 7) / 8;
        add_start(seed, len_b);
        for (int i = 0; i < words; i++)
        begin
            add_data(rand64());
        end
        n = words + 1;
    endtask

    task automatic add_directed();
        int n;
        add_data('1);
        add_start(64'd0, 32'd0);
        add_start('1, 32'd0);
        add_start(rand64(), 32'hFFFF_FFFF);
        add_data(64'd0);
        add_data('1);
        add_start('1, 32'd8);
        add_data('1);
        add_start(64'd0, 32'd1);
        add_data('1);
        add_start(rand64(), 32'd7);
        add_data('1);
        add_message(rand64(), 32'd32, n);
        add_message(rand64(), 32'd45, n);
        add_data(rand64());
    endtask

    task automatic add_random(input int count);
        int made;
        int r;
        int n;
        logic [31:0] len_b;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                add_data(rand64());
            end
            else if (r < 14)
            begin
                len_b = $urandom;
                if (len_b < 32'd64)
                begin
                    len_b += 32'd64;
                end
                add_start(rand64(), len_b);
                n = $urandom_range(3);
                for (int i = 0; i < n; i++)
                begin
                    add_data(rand64());
                end
                made += n + 1;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    len_b = $urandom_range(1, 40);
                end
                else if (r < 90)
                begin
                    len_b = $urandom_range(41, 160);
                end
                else if (r < 95)
                begin
                    len_b = 32'd0;
                end
                else
                begin
                    len_b = $urandom_range(161, 600);
                end
                add_message(rand64(), len_b, n);
                made += n;
            end
        end
        add_message(rand64(), $urandom_range(1, 40), n);
    endtask

    task automatic wait_drained();
        while (send_queue.size() != 0 || s_axis_tvalid || hashes_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_cross_rot(input logic [5:0] value);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cross_rot = value;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d hashes outstanding", cycles,
                     hashes_due.size());
            $display("FAIL four_lane_word_hash_64_core");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] digest;
        bit take;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_accepted++;
                if (hash_absorb(offered, digest))
                begin
                    hashes_due.push_back(digest);
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                take = send_queue.size() != 0 && $urandom_range(99) >= idle_pct;
                if (take)
                begin
                    offered = send_queue.pop_front();
                    s_axis_tdata <= {offered.len_b, offered.seed, offered.word};
                    s_axis_tuser <= offered.kind;
                end
                s_axis_tvalid <= take;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hashes_due.size() == 0)
                begin
                    report_mismatch($sformatf("hash %h with none expected", m_axis_tdata));
                end
                else
                begin
                    want = hashes_due.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        report_mismatch($sformatf("hash_value %h, expected %h",
                                                  m_axis_tdata, want));
                    end
                end
                hashes_checked++;
            end
            if (!held_once && hashes_checked >= 50 && send_queue.size() > 20)
            begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= $urandom_range(99) >= idle_pct;
            end
        end
    end

    initial
    begin
        acc1 = '0;
        acc2 = '0;
        acc3 = '0;
        acc4 = '0;
        byte_total = '0;
        words_seen = '0;
        in_message = 1'b0;
        cross_rot = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_cross_rot(6'd0);
        add_directed();
        add_random(180);
        wait_drained();

        write_cross_rot(6'd63);
        add_directed();
        add_random(180);
        wait_drained();

        // This phase runs with both sides always ready.
        write_cross_rot(6'd1);
        idle_pct = 0;
        add_random(180);
        wait_drained();
        idle_pct = 32;

        // The sender stops halfway until every hash so far has come back.
        write_cross_rot(6'($urandom_range(2, 62)));
        add_random(90);
        wait_drained();
        add_random(90);
        wait_drained();

        write_cross_rot(6'($urandom_range(63)));
        add_random(180);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (hashes_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d hashes never arrived", hashes_due.size()));
        end
        $display("Accepted %0d items over %0d started messages and checked %0d hashes.",
                 items_accepted, messages_planned, hashes_checked);
        $display("Five cross-mix settings were used, with idle gaps, a full-rate phase, "
                 , "a long output stall and a sender pause.");
        if (errors == 0)
        begin
            $display("PASS four_lane_word_hash_64_core");
        end
        else
        begin
            $display("FAIL four_lane_word_hash_64_core");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wlh_pkg.sv
design/wlh_fifo.sv
design/wlh_front.sv
design/wlh_mul.sv
design/wlh_back.sv
design/four_lane_word_hash_64_core.sv
bench/tb.sv
